### sv/bfw_pkg.sv
// Shared constants, types and helpers of the bilateral filter window unit.
`default_nettype none
package bfw_pkg;

  localparam int WINDOW_DEF      = 5;
  localparam int MAX_WIDTH_DEF   = 1024;
  localparam int CHANNELS_DEF    = 3;
  localparam int WEIGHT_FRAC_DEF = 16;

  localparam int PIX_W      = 24;
  localparam int SAMPLE_W   = 8;
  localparam int WEIGHT_W   = 17;
  localparam int INDEX_W    = 8;
  localparam int RANGE_SZ   = 256;
  localparam int ROW_W      = 12;
  localparam int MAX_HEIGHT = 4096;
  localparam int DIM_W      = 13;
  localparam int QUOT_W     = 8;
  localparam int ACTION_W   = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;
  localparam int IWIDTH_W   = 11;
  localparam int IHEIGHT_W  = 13;
  localparam int CHCNT_W    = 2;

  localparam logic [ACTION_W-1:0] ACT_RANGE   = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_SPATIAL = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_PIXEL   = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_WIDTH    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CHANNELS = 2'd2;

  localparam logic [IWIDTH_W-1:0]  WIDTH_RST    = 11'd640;
  localparam logic [IHEIGHT_W-1:0] HEIGHT_RST   = 13'd480;
  localparam logic [CHCNT_W-1:0]   CHANNELS_RST = 2'd3;

  typedef struct packed {
    logic                range_we;
    logic                spatial_we;
    logic [INDEX_W-1:0]  index;
    logic [WEIGHT_W-1:0] weight;
  } bfw_table_wr_t;

  typedef struct packed {
    logic clear;
    logic issue;
  } bfw_mac_ctrl_t;

  function automatic logic [SAMPLE_W-1:0] sample(input logic [PIX_W-1:0] pix,
                                                 input logic [1:0] ch);
    logic [SAMPLE_W-1:0] s;
    unique case (ch)
      2'd0:    s = pix[7:0];
      2'd1:    s = pix[15:8];
      default: s = pix[23:16];
    endcase
    return s;
  endfunction

endpackage
`default_nettype wire

### sv/bfw_cell.sv
// One window cell: holds a packed pixel, takes its neighbour or an inserted column value.
`default_nettype none
module bfw_cell (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      en,
  input  wire logic                      ins_sel,
  input  wire logic [bfw_pkg::PIX_W-1:0] ins,
  input  wire logic [bfw_pkg::PIX_W-1:0] nbr,
  output logic      [bfw_pkg::PIX_W-1:0] q
);

  always_ff @(posedge clk) begin
    if (rst) begin
      q <= '0;
    end else if (en) begin
      q <= ins_sel ? ins : nbr;
    end
  end

endmodule
`default_nettype wire

### sv/bfw_line_store.sv
// Line stores: one memory per buffered row, read and written at the current column.
`default_nettype none
module bfw_line_store #(
  parameter int WINDOW    = bfw_pkg::WINDOW_DEF,
  parameter int MAX_WIDTH = bfw_pkg::MAX_WIDTH_DEF
) (
  input  wire logic                                 clk,
  input  wire logic                                 en,
  input  wire logic [$clog2(MAX_WIDTH)-1:0]         col,
  input  wire logic [$clog2(WINDOW-1)-1:0]          base,
  input  wire logic [bfw_pkg::PIX_W-1:0]            pix,
  output logic      [WINDOW-2:0][bfw_pkg::PIX_W-1:0] col_data
);

  localparam int LINES  = WINDOW - 1;
  localparam int SLOT_W = $clog2(LINES);

  logic [LINES-1:0][bfw_pkg::PIX_W-1:0] rd;
  logic [SLOT_W-1:0]                    base_q;

  for (genvar k = 0; k < LINES; k++) begin : g_line
    logic [bfw_pkg::PIX_W-1:0] mem [MAX_WIDTH];
    always_ff @(posedge clk) begin
      if (en) begin
        rd[k] <= mem[col];
        if (base == SLOT_W'(k)) begin
          mem[col] <= pix;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      base_q <= base;
    end
  end

  always_comb begin
    logic [SLOT_W:0] s;
    for (int r = 0; r < LINES; r++) begin
      s = (SLOT_W + 1)'(base_q) + (SLOT_W + 1)'(r);
      if (s >= (SLOT_W + 1)'(LINES)) begin
        s = s - (SLOT_W + 1)'(LINES);
      end
      col_data[r] = rd[s[SLOT_W-1:0]];
    end
  end

endmodule
`default_nettype wire

### sv/bfw_weight_mac.sv
// Weight tables and the three-stage weight, multiply and accumulate pipeline.
`default_nettype none
module bfw_weight_mac #(
  parameter int WINDOW      = bfw_pkg::WINDOW_DEF,
  parameter int WEIGHT_FRAC = bfw_pkg::WEIGHT_FRAC_DEF
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire bfw_pkg::bfw_table_wr_t                wr,
  input  wire bfw_pkg::bfw_mac_ctrl_t                ctrl,
  input  wire logic [$clog2(WINDOW*WINDOW)-1:0]      tap,
  input  wire logic [bfw_pkg::SAMPLE_W-1:0]          nv,
  input  wire logic [bfw_pkg::SAMPLE_W-1:0]          cv,
  output logic      [bfw_pkg::SAMPLE_W + 2*bfw_pkg::WEIGHT_W - WEIGHT_FRAC
                     + $clog2(WINDOW*WINDOW+1)-1:0]  num,
  output logic      [2*bfw_pkg::WEIGHT_W - WEIGHT_FRAC
                     + $clog2(WINDOW*WINDOW+1)-1:0]  den,
  output logic                                       busy
);

  localparam int TAPS   = WINDOW * WINDOW;
  localparam int TAP_W  = $clog2(TAPS);
  localparam int PROD_W = 2 * bfw_pkg::WEIGHT_W;
  localparam int W_W    = PROD_W - WEIGHT_FRAC;
  localparam int EXT    = $clog2(TAPS + 1);
  localparam int NUM_W  = bfw_pkg::SAMPLE_W + W_W + EXT;
  localparam int DEN_W  = W_W + EXT;

  logic [bfw_pkg::WEIGHT_W-1:0] range_mem [bfw_pkg::RANGE_SZ];
  logic [bfw_pkg::WEIGHT_W-1:0] spatial_mem [TAPS];
  logic [bfw_pkg::WEIGHT_W-1:0] rw;
  logic [bfw_pkg::WEIGHT_W-1:0] sw;
  logic [bfw_pkg::SAMPLE_W-1:0] nv1;
  logic [bfw_pkg::SAMPLE_W-1:0] nv2;
  logic [PROD_W-1:0]            prod;
  logic                         v1;
  logic                         v2;
  logic [bfw_pkg::SAMPLE_W-1:0] diff;
  logic [W_W-1:0]               wgt;

  assign diff = (nv > cv) ? nv - cv : cv - nv;
  assign wgt  = prod[PROD_W-1:WEIGHT_FRAC];
  assign busy = v1 | v2;

  always_ff @(posedge clk) begin
    if (wr.range_we) begin
      range_mem[wr.index] <= wr.weight;
    end
    if (wr.spatial_we) begin
      spatial_mem[wr.index[TAP_W-1:0]] <= wr.weight;
    end
    if (ctrl.issue) begin
      rw <= range_mem[diff];
      sw <= spatial_mem[tap];
    end
  end

  always_ff @(posedge clk) begin
    nv1  <= nv;
    nv2  <= nv1;
    prod <= sw * rw;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1  <= 1'b0;
      v2  <= 1'b0;
      num <= '0;
      den <= '0;
    end else begin
      v1 <= ctrl.issue;
      v2 <= v1;
      if (ctrl.clear) begin
        num <= '0;
        den <= '0;
      end else if (v2) begin
        num <= num + NUM_W'(nv2) * NUM_W'(wgt);
        den <= den + DEN_W'(wgt);
      end
    end
  end

endmodule
`default_nettype wire

### sv/bfw_divider.sv
// Restoring divider: eight quotient bits, one per cycle; a zero divisor gives zero.
`default_nettype none
module bfw_divider #(
  parameter int NUM_W = 31,
  parameter int DEN_W = 23
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  input  wire logic [NUM_W-1:0]              num,
  input  wire logic [DEN_W-1:0]              den,
  output logic      [bfw_pkg::QUOT_W-1:0]    quot,
  output logic                               done
);

  localparam int STEP_W = $clog2(bfw_pkg::QUOT_W);
  localparam int CMP_W  = DEN_W + bfw_pkg::QUOT_W;

  logic [CMP_W-1:0]           rem;
  logic [CMP_W-1:0]           dsh;
  logic [bfw_pkg::QUOT_W-1:0] q;
  logic [STEP_W-1:0]          step;
  logic                       run;
  logic                       zero;
  logic                       fits;

  assign fits = rem >= dsh;
  assign quot = zero ? '0 : q;

  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= CMP_W'(num);
      dsh  <= CMP_W'({den, (bfw_pkg::QUOT_W - 1)'(0)});
      zero <= (den == '0);
    end else if (run) begin
      if (fits) begin
        rem <= rem - dsh;
      end
      q   <= {q[bfw_pkg::QUOT_W-2:0], fits};
      dsh <= dsh >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      step <= '0;
      done <= 1'b0;
    end else begin
      done <= run && (step == '0);
      if (start) begin
        run  <= 1'b1;
        step <= STEP_W'(bfw_pkg::QUOT_W - 1);
      end else if (run) begin
        if (step == '0) begin
          run <= 1'b0;
        end else begin
          step <= step - 1'b1;
        end
      end
    end
  end

endmodule
`default_nettype wire

### sv/bilateral_filter_window_unit.sv
// Top level: raster counters, window cell chain, channel sequencer and result register.
//   channel | signals                            | transaction moves
//   in      | s_tvalid s_tready s_tdata s_tuser  | one load or pixel item
//   out     | m_tvalid m_tready m_tdata m_tlast  | one filtered centre pixel
//   config  | cfg_we cfg_index cfg_data          | one register write
// Load items and border pixels are taken without filtering; an interior pixel
// holds off the input while the cell chain rotates through the single
// multiply-accumulate pipeline and the eight-step divider once per channel.
// Reset is synchronous and clears the counters and the chain; the weight tables
// and line stores hold nothing until written.
// A result waiting in the output register blocks only the next result.
`default_nettype none
module bilateral_filter_window_unit #(
  parameter int WINDOW      = bfw_pkg::WINDOW_DEF,
  parameter int MAX_WIDTH   = bfw_pkg::MAX_WIDTH_DEF,
  parameter int CHANNELS    = bfw_pkg::CHANNELS_DEF,
  parameter int WEIGHT_FRAC = bfw_pkg::WEIGHT_FRAC_DEF
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  s_tvalid,
  output logic                                       s_tready,
  // table_index, table_weight, pixel_c0, pixel_c1, pixel_c2, zero fill
  input  wire logic [55:0]                           s_tdata,
  // action
  input  wire logic [bfw_pkg::ACTION_W-1:0]          s_tuser,
  output logic                                       m_tvalid,
  input  wire logic                                  m_tready,
  // out_x, out_y, out_c0, out_c1, out_c2, zero fill
  output logic [(($clog2(MAX_WIDTH) + 36 + 7) / 8) * 8 - 1:0] m_tdata,
  output logic                                       m_tlast,
  input  wire logic                                  cfg_we,
  input  wire logic [bfw_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  wire logic [bfw_pkg::CFG_DATA_W-1:0]        cfg_data
);

  localparam int TAPS   = WINDOW * WINDOW;
  localparam int TAP_W  = $clog2(TAPS);
  localparam int RADIUS = WINDOW / 2;
  localparam int CENTER = RADIUS * WINDOW + RADIUS;
  localparam int LINES  = WINDOW - 1;
  localparam int SLOT_W = $clog2(LINES);
  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int ROW_W  = bfw_pkg::ROW_W;
  localparam int DIM_W  = bfw_pkg::DIM_W;
  localparam int W_W    = 2 * bfw_pkg::WEIGHT_W - WEIGHT_FRAC;
  localparam int EXT    = $clog2(TAPS + 1);
  localparam int NUM_W  = bfw_pkg::SAMPLE_W + W_W + EXT;
  localparam int DEN_W  = W_W + EXT;
  localparam int ODW    = ((COL_W + 36 + 7) / 8) * 8;
  localparam int PW     = bfw_pkg::PIX_W;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_LOAD  = 6'b000010,
    S_SCAN  = 6'b000100,
    S_DRAIN = 6'b001000,
    S_DIV   = 6'b010000,
    S_OUT   = 6'b100000
  } state_t;

  state_t state;
  state_t state_next;

  logic [bfw_pkg::IWIDTH_W-1:0]  image_width;
  logic [bfw_pkg::IHEIGHT_W-1:0] image_height;
  logic [bfw_pkg::CHCNT_W-1:0]   channel_count;

  logic [COL_W-1:0]  column_count;
  logic [ROW_W-1:0]  row_count;
  logic [SLOT_W-1:0] base;

  logic [DIM_W-1:0]  w_eff;
  logic [DIM_W-1:0]  h_eff;
  logic [1:0]        nch;
  logic [DIM_W-1:0]  col_p1;
  logic [DIM_W-1:0]  row_p1;
  logic              col_wrap;
  logic              row_wrap;

  logic              accept;
  logic              pix_accept;
  logic [PW-1:0]     pix_in;
  logic [PW-1:0]     pix_q;
  logic              produce;
  logic [COL_W-1:0]  res_x;
  logic [ROW_W-1:0]  res_y;
  logic              res_last;
  logic [PW-1:0]     center;
  logic [1:0]        ch;
  logic [TAP_W-1:0]  tap;
  logic [bfw_pkg::QUOT_W-1:0] res [3];

  logic [LINES-1:0][PW-1:0] col_data;
  logic [PW-1:0]            win [TAPS];
  logic                     chain_en;
  logic                     chain_ins;

  bfw_pkg::bfw_table_wr_t   twr;
  bfw_pkg::bfw_mac_ctrl_t   mctl;
  logic [NUM_W-1:0]         num;
  logic [DEN_W-1:0]         den;
  logic                     mac_busy;
  logic                     div_start;
  logic [bfw_pkg::QUOT_W-1:0] quot;
  logic                     div_done;

  assign s_tready   = (state == S_IDLE);
  assign accept     = s_tvalid && s_tready;
  assign pix_accept = accept && (s_tuser == bfw_pkg::ACT_PIXEL);
  assign pix_in     = s_tdata[48:25];

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width   <= bfw_pkg::WIDTH_RST;
      image_height  <= bfw_pkg::HEIGHT_RST;
      channel_count <= bfw_pkg::CHANNELS_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        bfw_pkg::REG_WIDTH:    image_width   <= cfg_data[bfw_pkg::IWIDTH_W-1:0];
        bfw_pkg::REG_HEIGHT:   image_height  <= cfg_data[bfw_pkg::IHEIGHT_W-1:0];
        bfw_pkg::REG_CHANNELS: channel_count <= cfg_data[bfw_pkg::CHCNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    w_eff = DIM_W'(image_width);
    if (image_width == '0) begin
      w_eff = DIM_W'(1);
    end else if (DIM_W'(image_width) > DIM_W'(MAX_WIDTH)) begin
      w_eff = DIM_W'(MAX_WIDTH);
    end
    h_eff = image_height;
    if (image_height == '0) begin
      h_eff = DIM_W'(1);
    end else if (image_height > DIM_W'(bfw_pkg::MAX_HEIGHT)) begin
      h_eff = DIM_W'(bfw_pkg::MAX_HEIGHT);
    end
    nch = channel_count;
    if (channel_count == '0) begin
      nch = 2'd1;
    end else if (32'(channel_count) > CHANNELS) begin
      nch = 2'(CHANNELS);
    end
  end

  assign col_p1   = DIM_W'(column_count) + DIM_W'(1);
  assign row_p1   = DIM_W'(row_count) + DIM_W'(1);
  assign col_wrap = col_p1 >= w_eff;
  assign row_wrap = row_p1 >= h_eff;

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
      base         <= '0;
    end else if (pix_accept) begin
      if (col_wrap) begin
        column_count <= '0;
        if (row_wrap) begin
          row_count <= '0;
          base      <= '0;
        end else begin
          row_count <= row_count + 1'b1;
          base      <= (32'(base) == LINES - 1) ? '0 : base + 1'b1;
        end
      end else begin
        column_count <= column_count + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pix_accept) begin
      pix_q    <= pix_in;
      res_x    <= column_count - COL_W'(RADIUS);
      res_y    <= row_count - ROW_W'(RADIUS);
      res_last <= col_wrap && row_wrap;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      produce <= 1'b0;
    end else if (pix_accept) begin
      produce <= (32'(column_count) >= 2 * RADIUS) && (32'(row_count) >= 2 * RADIUS);
    end
  end

  bfw_line_store #(
    .WINDOW    (WINDOW),
    .MAX_WIDTH (MAX_WIDTH)
  ) u_line_store (
    .clk      (clk),
    .en       (pix_accept),
    .col      (column_count),
    .base     (base),
    .pix      (pix_in),
    .col_data (col_data)
  );

  assign chain_en  = (state == S_LOAD) || (state == S_SCAN);
  assign chain_ins = (state == S_LOAD);

  for (genvar k = 0; k < TAPS; k++) begin : g_cell
    localparam int R  = k / WINDOW;
    localparam int C  = k % WINDOW;
    localparam int NB = (k + 1) % TAPS;
    logic [PW-1:0] ins;
    if (R == WINDOW - 1) begin : g_new
      assign ins = pix_q;
    end else begin : g_line
      assign ins = col_data[R];
    end
    bfw_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .en      (chain_en),
      .ins_sel (chain_ins && (C == WINDOW - 1)),
      .ins     (ins),
      .nbr     (win[NB]),
      .q       (win[k])
    );
  end

  always_ff @(posedge clk) begin
    if (state == S_LOAD) begin
      center <= win[CENTER + 1];
    end
  end

  assign twr.range_we   = accept && (s_tuser == bfw_pkg::ACT_RANGE);
  assign twr.spatial_we = accept && (s_tuser == bfw_pkg::ACT_SPATIAL)
                          && (32'(s_tdata[7:0]) < TAPS);
  assign twr.index      = s_tdata[7:0];
  assign twr.weight     = s_tdata[24:8];

  assign mctl.issue = (state == S_SCAN);
  assign mctl.clear = ((state == S_LOAD) && produce)
                      || ((state == S_DIV) && div_done && (ch + 2'd1 < nch));

  bfw_weight_mac #(
    .WINDOW      (WINDOW),
    .WEIGHT_FRAC (WEIGHT_FRAC)
  ) u_mac (
    .clk  (clk),
    .rst  (rst),
    .wr   (twr),
    .ctrl (mctl),
    .tap  (tap),
    .nv   (bfw_pkg::sample(win[0], ch)),
    .cv   (bfw_pkg::sample(center, ch)),
    .num  (num),
    .den  (den),
    .busy (mac_busy)
  );

  assign div_start = (state == S_DRAIN) && !mac_busy;

  bfw_divider #(
    .NUM_W (NUM_W),
    .DEN_W (DEN_W)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (num),
    .den   (den),
    .quot  (quot),
    .done  (div_done)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:  if (pix_accept) state_next = S_LOAD;
      S_LOAD:  state_next = produce ? S_SCAN : S_IDLE;
      S_SCAN:  if (32'(tap) == TAPS - 1) state_next = S_DRAIN;
      S_DRAIN: if (!mac_busy) state_next = S_DIV;
      S_DIV: begin
        if (div_done) begin
          state_next = (ch + 2'd1 < nch) ? S_SCAN : S_OUT;
        end
      end
      S_OUT:   if (!m_tvalid || m_tready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      tap   <= '0;
      ch    <= '0;
    end else begin
      state <= state_next;
      if (state == S_SCAN) begin
        tap <= (32'(tap) == TAPS - 1) ? '0 : tap + 1'b1;
      end
      if (state == S_LOAD) begin
        ch <= '0;
      end else if ((state == S_DIV) && div_done) begin
        ch <= ch + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_LOAD) begin
      for (int i = 0; i < 3; i++) begin
        res[i] <= '0;
      end
    end else if ((state == S_DIV) && div_done) begin
      res[ch] <= quot;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if ((state == S_OUT) && (!m_tvalid || m_tready)) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == S_OUT) && (!m_tvalid || m_tready)) begin
      m_tdata <= ODW'({res[2], res[1], res[0], res_y, res_x});
      m_tlast <= res_last;
    end
  end

  a_tap_range: assert property (@(posedge clk) disable iff (rst)
    state == S_SCAN |-> 32'(tap) < TAPS)
    else $error("tap index beyond the window during scan");

  a_ch_range: assert property (@(posedge clk) disable iff (rst)
    state == S_SCAN |-> ch < nch)
    else $error("channel index beyond the active channel count");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (state == S_OUT) && m_tvalid && !m_tready |=> state == S_OUT)
    else $error("result left the sequencer while the output register was full");

  a_div_done: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == S_DIV)
    else $error("divider finished outside the divide phase");

endmodule
`default_nettype wire

### tb/sv/bfw_checker.sv
// Checker for the bilateral filter window unit: predicts filtered pixels and compares results.
module bfw_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [55:0] s_tdata,
  input  logic [1:0]  s_tuser,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [47:0] m_tdata,
  input  logic        m_tlast,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [12:0] cfg_data,
  output int          errors,
  output int          pending
);

  typedef struct packed {
    logic [9:0]  x;
    logic [11:0] y;
    logic [7:0]  c0;
    logic [7:0]  c1;
    logic [7:0]  c2;
    logic        last;
  } filtered_px_t;

  logic [10:0] width_reg;
  logic [12:0] height_reg;
  logic [1:0]  chan_reg;
  logic [16:0] range_tab [256];
  logic [16:0] spatial_tab [25];
  logic [23:0] rows_mem [4*1024];
  logic [23:0] win [25];
  int unsigned col_cnt;
  int unsigned row_cnt;
  filtered_px_t expected_px [$];

  assign pending = expected_px.size();

  task automatic report(input string what, input int got, input int want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    errors++;
  endtask

  task automatic filter_pixel(input logic [23:0] pix);
    int unsigned w, h, nch, col, row, cv, nv, diff;
    longint unsigned num, den, wgt;
    logic [7:0] res [3];
    logic [23:0] centre;
    filtered_px_t px;
    w = (width_reg == 0) ? 1 : (width_reg > 1024 ? 1024 : width_reg);
    h = (height_reg == 0) ? 1 : (height_reg > 4096 ? 4096 : height_reg);
    nch = (chan_reg == 0) ? 1 : chan_reg;
    col = col_cnt % 1024;
    row = row_cnt % 4096;
    for (int r = 0; r < 5; r++)
      for (int c = 0; c < 4; c++) win[r*5+c] = win[r*5+c+1];
    for (int r = 0; r < 4; r++) win[r*5+4] = rows_mem[((row + r) % 4) * 1024 + col];
    win[24] = pix;
    rows_mem[(row % 4) * 1024 + col] = pix;
    if (col >= 4 && row >= 4) begin
      centre = win[12];
      res = '{default: 8'd0};
      for (int ch = 0; ch < nch; ch++) begin
        cv = (centre >> (8 * ch)) & 8'hFF;
        num = 0;
        den = 0;
        for (int t = 0; t < 25; t++) begin
          nv = (win[t] >> (8 * ch)) & 8'hFF;
          diff = nv > cv ? nv - cv : cv - nv;
          wgt = (64'(spatial_tab[t]) * 64'(range_tab[diff])) >> 16;
          num += nv * wgt;
          den += wgt;
        end
        res[ch] = (den == 0) ? 8'd0 : 8'(num / den);
      end
      px.x = 10'(col - 2);
      px.y = 12'(row - 2);
      px.c0 = res[0];
      px.c1 = res[1];
      px.c2 = res[2];
      px.last = (col + 1 >= w) && (row + 1 >= h);
      expected_px.push_back(px);
    end
    if (col + 1 >= w) begin
      col_cnt = 0;
      row_cnt = (row + 1 >= h) ? 0 : row + 1;
    end else begin
      col_cnt = col + 1;
      row_cnt = row;
    end
  endtask

  always @(posedge clk) begin
    filtered_px_t want;
    if (rst) begin
      width_reg <= bfw_pkg::WIDTH_RST;
      height_reg <= bfw_pkg::HEIGHT_RST;
      chan_reg <= bfw_pkg::CHANNELS_RST;
      col_cnt = 0;
      row_cnt = 0;
      for (int t = 0; t < 25; t++) win[t] = '0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (expected_px.size() == 0) begin
          $display("unexpected result transaction: data %h last %b", m_tdata, m_tlast);
          errors++;
        end else begin
          want = expected_px.pop_front();
          if (m_tdata[9:0] != want.x) report("out_x", m_tdata[9:0], want.x);
          if (m_tdata[21:10] != want.y) report("out_y", m_tdata[21:10], want.y);
          if (m_tdata[29:22] != want.c0) report("out_c0", m_tdata[29:22], want.c0);
          if (m_tdata[37:30] != want.c1) report("out_c1", m_tdata[37:30], want.c1);
          if (m_tdata[45:38] != want.c2) report("out_c2", m_tdata[45:38], want.c2);
          if (m_tlast != want.last) report("frame_last", m_tlast, want.last);
        end
      end
      if (s_tvalid && s_tready) begin
        case (s_tuser)
          bfw_pkg::ACT_RANGE: range_tab[s_tdata[7:0]] = s_tdata[24:8];
          bfw_pkg::ACT_SPATIAL:
            if (s_tdata[7:0] < 25) spatial_tab[s_tdata[7:0]] = s_tdata[24:8];
          bfw_pkg::ACT_PIXEL: filter_pixel(s_tdata[48:25]);
          default: ;
        endcase
      end
      if (cfg_we) begin
        case (cfg_index)
          bfw_pkg::REG_WIDTH: width_reg <= cfg_data[10:0];
          bfw_pkg::REG_HEIGHT: height_reg <= cfg_data[12:0];
          bfw_pkg::REG_CHANNELS: chan_reg <= cfg_data[1:0];
          default: ;
        endcase
      end
    end
  end

  initial errors = 0;
endmodule

### tb/sv/testbench.sv
// Top of the bilateral filter window unit testbench: stimulus, stalls and verdict.
module testbench;

  localparam logic [bfw_pkg::ACTION_W-1:0] ACT_NONE = 2'd3;
  localparam int CYCLE_LIMIT = 1500000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [55:0] s_tdata = '0;
  logic [1:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [47:0] m_tdata;
  logic        m_tlast;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [12:0] cfg_data = '0;
  int          errors;
  int          pending;
  int          cycles = 0;
  bit          tx_gaps = 1'b1;
  bit          rx_gaps = 1'b1;
  bit          rx_hold = 1'b0;
  int unsigned frame_w = 640, frame_h = 480;
  int unsigned pos_col = 0, pos_row = 0;
  int          item_count = 0;

  always #6 clk = ~clk;

  bilateral_filter_window_unit i_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  bfw_checker i_checker (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .errors(errors), .pending(pending)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("bilateral_filter_window_unit verification failed");
      $finish;
    end
  end

  initial begin
    int n;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (rx_hold) begin
        m_tready <= 1'b0;
        repeat (600) @(posedge clk);
        rx_hold = 1'b0;
      end
      n = rx_gaps ? $urandom_range(0, 9) : 0;
      if (n > 0) begin
        m_tready <= 1'b0;
        repeat (n) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!(m_tvalid && m_tready));
    end
  end

  task automatic send_item(input logic [1:0] act, input logic [7:0] idx,
                           input logic [16:0] wt, input logic [23:0] pix);
    int n;
    n = tx_gaps ? $urandom_range(0, 9) : 0;
    if (n > 0) begin
      s_tvalid <= 1'b0;
      repeat (n) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= act;
    s_tdata <= {7'd0, pix, wt, idx};
    do @(posedge clk); while (!(s_tvalid && s_tready));
    if (act == bfw_pkg::ACT_PIXEL) begin
      if (pos_col + 1 >= frame_w) begin
        pos_col = 0;
        pos_row = (pos_row + 1 >= frame_h) ? 0 : pos_row + 1;
      end else begin
        pos_col++;
      end
    end
    item_count++;
  endtask

  function automatic logic [16:0] rand_weight();
    case ($urandom_range(0, 7))
      0: return 17'd0;
      1: return 17'd65536;
      default: return 17'($urandom_range(0, 65535));
    endcase
  endfunction

  function automatic logic [23:0] rand_pixel(input logic [23:0] base);
    if ($urandom_range(0, 3) == 0) return 24'($urandom);
    return {8'(base[23:16] + $urandom_range(0, 6)), 8'(base[15:8] + $urandom_range(0, 6)),
            8'(base[7:0] + $urandom_range(0, 6))};
  endfunction

  task automatic drain();
    s_tvalid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (150) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [12:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == bfw_pkg::REG_WIDTH) frame_w = val == 0 ? 1 : (val > 1024 ? 1024 : val);
    if (idx == bfw_pkg::REG_HEIGHT) frame_h = val == 0 ? 1 : (val > 4096 ? 4096 : val);
  endtask

  task automatic send_frame(input bit noisy);
    logic [23:0] base;
    base = 24'($urandom);
    do begin
      if (noisy && $urandom_range(0, 11) == 0) begin
        case ($urandom_range(0, 2))
          0: send_item(bfw_pkg::ACT_RANGE, 8'($urandom), rand_weight(), 24'($urandom));
          1: send_item(bfw_pkg::ACT_SPATIAL, 8'($urandom_range(0, 31)), rand_weight(),
                       24'($urandom));
          default: send_item(ACT_NONE, 8'($urandom), 17'($urandom), 24'($urandom));
        endcase
      end
      send_item(bfw_pkg::ACT_PIXEL, 8'($urandom), 17'($urandom), rand_pixel(base));
    end while (!(pos_col == 0 && pos_row == 0));
  endtask

  task automatic load_tables(input bit zero_spatial);
    for (int i = 0; i < 256; i++)
      send_item(bfw_pkg::ACT_RANGE, 8'(i),
                i == 0 ? 17'd65536 : (i == 255 ? 17'd0 : rand_weight()), 24'($urandom));
    for (int i = 0; i < 25; i++)
      send_item(bfw_pkg::ACT_SPATIAL, 8'(i),
                zero_spatial ? 17'd0 : (i == 12 ? 17'd65536 : rand_weight()), 24'($urandom));
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    write_reg(bfw_pkg::REG_WIDTH, 13'd6);
    write_reg(bfw_pkg::REG_HEIGHT, 13'd6);
    write_reg(bfw_pkg::REG_CHANNELS, 13'd3);
    load_tables(1'b0);

    send_item(ACT_NONE, 8'hFF, 17'h1FFFF, 24'hFFFFFF);
    send_item(bfw_pkg::ACT_SPATIAL, 8'd25, 17'd0, 24'd0);
    send_item(bfw_pkg::ACT_SPATIAL, 8'd255, 17'd0, 24'd0);
    for (int i = 0; i < 36; i++)
      send_item(bfw_pkg::ACT_PIXEL, 8'hFF, 17'h1FFFF,
                (i % 3 == 0) ? 24'hFFFFFF : ((i % 3 == 1) ? 24'h0 : 24'hFF00FF));

    // all spatial weights zero: every weight sum vanishes
    load_tables(1'b1);
    send_frame(1'b0);
    load_tables(1'b0);

    tx_gaps = 1'b0;
    rx_hold = 1'b1;
    send_frame(1'b0);
    drain();

    item_count = 0;
    while (item_count < 1200) begin
      tx_gaps = $urandom_range(0, 3) != 0;
      rx_gaps = $urandom_range(0, 3) != 0;
      write_reg(bfw_pkg::REG_WIDTH, 13'($urandom_range(6, 12)));
      write_reg(bfw_pkg::REG_HEIGHT, 13'($urandom_range(6, 9)));
      write_reg(bfw_pkg::REG_CHANNELS, 13'($urandom_range(0, 3)));
      repeat ($urandom_range(1, 2)) send_frame(1'b1);
      drain();
    end

    tx_gaps = 1'b0;
    rx_gaps = 1'b0;
    write_reg(bfw_pkg::REG_WIDTH, 13'd2047);
    write_reg(bfw_pkg::REG_HEIGHT, 13'd6);
    write_reg(bfw_pkg::REG_CHANNELS, 13'd1);
    send_frame(1'b0);
    drain();

    tx_gaps = 1'b1;
    rx_gaps = 1'b1;
    write_reg(bfw_pkg::REG_WIDTH, 13'd6);
    write_reg(bfw_pkg::REG_HEIGHT, 13'd8191);
    write_reg(bfw_pkg::REG_CHANNELS, 13'd2);
    repeat (60) send_item(bfw_pkg::ACT_PIXEL, 8'd0, 17'd0, 24'($urandom));
    drain();
    write_reg(bfw_pkg::REG_HEIGHT, 13'd9);
    do send_item(bfw_pkg::ACT_PIXEL, 8'd0, 17'd0, 24'($urandom));
    while (!(pos_col == 0 && pos_row == 0));
    drain();

    if (errors == 0 && pending == 0) begin
      $display("bilateral_filter_window_unit verification clean");
    end else begin
      $display("bilateral_filter_window_unit verification failed");
    end
    $finish;
  end
endmodule

### sim.f
sv/bfw_pkg.sv
sv/bfw_cell.sv
sv/bfw_line_store.sv
sv/bfw_weight_mac.sv
sv/bfw_divider.sv
sv/bilateral_filter_window_unit.sv
tb/sv/bfw_checker.sv
tb/sv/testbench.sv
